### sv/lrs_pkg.sv
// Shared types and constants for the line ray stepper.
package lrs_pkg;

    localparam int DELTA_W = 10;
    localparam int ACC_W = 11;
    localparam int TOTAL_W = 16;
    localparam int REQ_W = 9;
    localparam int CNT_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_STEP_REQUEST = 255;

    localparam logic [CFG_IDX_W-1:0] REG_DELTA_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUADRANT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENDLESS = 2'd3;

    localparam logic [DELTA_W-1:0] DELTA_X_RESET = 10'd100;
    localparam logic [DELTA_W-1:0] DELTA_Y_RESET = 10'd0;
    localparam logic [1:0] QUADRANT_RESET = 2'd0;
    localparam logic ENDLESS_RESET = 1'b1;

    // Bit q is set where quadrant q negates that axis.
    localparam logic [3:0] QUAD_NEG_X = 4'b0110;
    localparam logic [3:0] QUAD_NEG_Y = 4'b1100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } lrs_state_t;

    typedef struct packed {
        logic clear;
        logic step;
    } lrs_core_ctl_t;

endpackage

### sv/lrs_step_core.sv
// Shared step unit: error accumulator, axis counters and the saturating step total.
module lrs_step_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lrs_pkg::lrs_core_ctl_t        ctl,
    input  logic [lrs_pkg::DELTA_W-1:0]   major,
    input  logic [lrs_pkg::DELTA_W-1:0]   minor,
    output logic [lrs_pkg::CNT_W-1:0]     major_cnt,
    output logic [lrs_pkg::CNT_W-1:0]     minor_cnt,
    output logic [lrs_pkg::TOTAL_W-1:0]   step_total
);

    logic [lrs_pkg::ACC_W-1:0]   error_accum_reg, error_accum_next;
    logic [lrs_pkg::TOTAL_W-1:0] step_total_reg, step_total_next;
    logic [lrs_pkg::CNT_W-1:0]   major_cnt_reg, major_cnt_next;
    logic [lrs_pkg::CNT_W-1:0]   minor_cnt_reg, minor_cnt_next;
    logic [lrs_pkg::ACC_W:0]     acc_sum;
    logic [lrs_pkg::ACC_W-1:0]   acc_add;
    logic                        minor_hit;

    assign acc_sum = {1'b0, error_accum_reg} + {2'b00, minor};
    assign acc_add = acc_sum[lrs_pkg::ACC_W-1:0];
    assign minor_hit = acc_add >= {1'b0, major};

    always_comb
    begin
        error_accum_next = error_accum_reg;
        step_total_next = step_total_reg;
        major_cnt_next = major_cnt_reg;
        minor_cnt_next = minor_cnt_reg;
        if (ctl.clear)
        begin
            major_cnt_next = '0;
            minor_cnt_next = '0;
        end
        else if (ctl.step)
        begin
            major_cnt_next = major_cnt_reg + 1'b1;
            if (minor_hit)
            begin
                error_accum_next = acc_add - {1'b0, major};
                minor_cnt_next = minor_cnt_reg + 1'b1;
            end
            else
            begin
                error_accum_next = acc_add;
            end
            // hold at the top instead of wrapping
            if (step_total_reg != '1)
            begin
                step_total_next = step_total_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_accum_reg <= '0;
            step_total_reg <= '0;
            major_cnt_reg <= '0;
            minor_cnt_reg <= '0;
        end
        else
        begin
            error_accum_reg <= error_accum_next;
            step_total_reg <= step_total_next;
            major_cnt_reg <= major_cnt_next;
            minor_cnt_reg <= minor_cnt_next;
        end
    end

    assign major_cnt = major_cnt_reg;
    assign minor_cnt = minor_cnt_reg;
    assign step_total = step_total_reg;

`ifndef ASSERT_OFF
    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (major_cnt_reg == '0) && (minor_cnt_reg == '0))
        else $error("counters not cleared");

    a_minor_le_major: assert property (@(posedge clk) disable iff (!rst_n)
        minor_cnt_reg <= major_cnt_reg)
        else $error("minor count passed major count");

    a_total_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        step_total_reg >= $past(step_total_reg))
        else $error("step total went backward");
`endif

endmodule

### sv/line_ray_stepper_unit.sv
// Top level of the line ray stepper: config registers, sequencer and result register.
// Request magnitudes |step_count| are clamped to 255; each request runs through RUN and DONE.
// The single shared step unit takes one major-axis step per cycle in RUN, and no request
// is taken until the result is loaded. Zero-step requests take no step but still pass DONE.
// Reset (rst_n, async low) restores config defaults and clears accumulator and step total.
module line_ray_stepper_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrs_pkg::DELTA_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [lrs_pkg::REQ_W-1:0]  step_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [lrs_pkg::CNT_W-1:0]  offset_x,
    output logic signed [lrs_pkg::CNT_W-1:0]  offset_y,
    output logic                              at_end
);

    logic [lrs_pkg::DELTA_W-1:0] delta_x_reg, delta_y_reg;
    logic [1:0]                  quadrant_reg;
    logic                        endless_reg;

    lrs_pkg::lrs_state_t         state_reg, state_next;
    lrs_pkg::lrs_core_ctl_t      ctl;
    logic                        accept;
    logic                        load_out;

    logic [lrs_pkg::REQ_W-1:0]   remaining_reg, remaining_next;
    logic [lrs_pkg::DELTA_W-1:0] major_reg, minor_reg;
    logic                        vert_reg, neg_x_reg, neg_y_reg;

    logic [lrs_pkg::REQ_W-1:0]   req_mag;
    logic [lrs_pkg::REQ_W-1:0]   req_clamped;
    logic                        vert;

    logic [lrs_pkg::CNT_W-1:0]   major_cnt, minor_cnt;
    logic [lrs_pkg::TOTAL_W-1:0] step_total;
    logic [lrs_pkg::CNT_W-1:0]   mag_x, mag_y;
    logic [lrs_pkg::TOTAL_W:0]   total_plus;
    logic                        end_flag;

    logic                        out_valid_reg;
    logic signed [lrs_pkg::CNT_W-1:0] offset_x_reg, offset_y_reg;
    logic                        at_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_x_reg <= lrs_pkg::DELTA_X_RESET;
            delta_y_reg <= lrs_pkg::DELTA_Y_RESET;
            quadrant_reg <= lrs_pkg::QUADRANT_RESET;
            endless_reg <= lrs_pkg::ENDLESS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lrs_pkg::REG_DELTA_X:  delta_x_reg <= cfg_data;
                lrs_pkg::REG_DELTA_Y:  delta_y_reg <= cfg_data;
                lrs_pkg::REG_QUADRANT: quadrant_reg <= cfg_data[1:0];
                lrs_pkg::REG_ENDLESS:  endless_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // magnitude of the two's complement request, then clamp
    assign req_mag = step_count[lrs_pkg::REQ_W-1] ? (~step_count + 1'b1) : step_count;
    assign req_clamped = (req_mag > lrs_pkg::REQ_W'(lrs_pkg::MAX_STEP_REQUEST))
                         ? lrs_pkg::REQ_W'(lrs_pkg::MAX_STEP_REQUEST) : req_mag;
    assign vert = delta_x_reg <= delta_y_reg;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        remaining_next = remaining_reg;
        ctl = '0;
        in_ready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            lrs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.clear = 1'b1;
                    remaining_next = req_clamped;
                    state_next = lrs_pkg::ST_RUN;
                end
            end
            lrs_pkg::ST_RUN:
            begin
                if (remaining_reg == '0)
                begin
                    state_next = lrs_pkg::ST_DONE;
                end
                else
                begin
                    ctl.step = 1'b1;
                    remaining_next = remaining_reg - 1'b1;
                end
            end
            lrs_pkg::ST_DONE:
            begin
                // load only when the result slot is free or draining
                if (!out_valid_reg || out_ready)
                begin
                    load_out = 1'b1;
                    state_next = lrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrs_pkg::ST_IDLE;
            remaining_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vert_reg <= vert;
            major_reg <= vert ? delta_y_reg : delta_x_reg;
            minor_reg <= vert ? delta_x_reg : delta_y_reg;
            neg_x_reg <= lrs_pkg::QUAD_NEG_X[quadrant_reg] ^ step_count[lrs_pkg::REQ_W-1];
            neg_y_reg <= lrs_pkg::QUAD_NEG_Y[quadrant_reg] ^ step_count[lrs_pkg::REQ_W-1];
        end
    end

    lrs_step_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .major      (major_reg),
        .minor      (minor_reg),
        .major_cnt  (major_cnt),
        .minor_cnt  (minor_cnt),
        .step_total (step_total)
    );

    assign mag_x = vert_reg ? minor_cnt : major_cnt;
    assign mag_y = vert_reg ? major_cnt : minor_cnt;
    assign total_plus = {1'b0, step_total} + 1'b1;
    assign end_flag = endless_reg
                      || (total_plus >= {{(lrs_pkg::TOTAL_W + 1 - lrs_pkg::DELTA_W){1'b0}},
                                         major_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            offset_x_reg <= neg_x_reg ? (~mag_x + 1'b1) : mag_x;
            offset_y_reg <= neg_y_reg ? (~mag_y + 1'b1) : mag_y;
            at_end_reg <= end_flag;
        end
    end

    assign out_valid = out_valid_reg;
    assign offset_x = offset_x_reg;
    assign offset_y = offset_y_reg;
    assign at_end = at_end_reg;

`ifndef ASSERT_OFF
    a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == lrs_pkg::ST_RUN))
        else $error("request accepted without starting a run");

    a_step_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> (remaining_reg != '0))
        else $error("step issued with no steps left");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("result loaded but not valid");
`endif

endmodule

### sim/ray_offset_checker.sv
// Watches the stepper channels, predicts each ray offset and compares the results.
module ray_offset_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lrs_pkg::DELTA_W-1:0]       cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic signed [lrs_pkg::REQ_W-1:0]  step_count,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [lrs_pkg::CNT_W-1:0]  offset_x,
    input  logic signed [lrs_pkg::CNT_W-1:0]  offset_y,
    input  logic                              at_end,
    output int                                fail_count,
    output int                                pending
);

    typedef struct packed {
        logic signed [lrs_pkg::CNT_W-1:0] off_x;
        logic signed [lrs_pkg::CNT_W-1:0] off_y;
        logic                             end_flag;
    } ray_offset_t;

    // Shadow of the configuration and of the stepping state
    logic [lrs_pkg::DELTA_W-1:0] x_span;
    logic [lrs_pkg::DELTA_W-1:0] y_span;
    logic [1:0]                  quad_sel;
    logic                        ray_endless;
    logic [lrs_pkg::ACC_W-1:0]   err_acc;
    logic [lrs_pkg::TOTAL_W-1:0] steps_taken;

    ray_offset_t expected_offsets[$];
    ray_offset_t want;

    function automatic ray_offset_t advance_ray(logic signed [lrs_pkg::REQ_W-1:0] req);
        logic                        neg;
        logic [lrs_pkg::DELTA_W-1:0] mag;
        logic                        vert;
        logic [lrs_pkg::DELTA_W-1:0] major_d;
        logic [lrs_pkg::DELTA_W-1:0] minor_d;
        int                          major_n;
        int                          minor_n;
        int                          ox;
        int                          oy;
        ray_offset_t                 r;
        neg = req[lrs_pkg::REQ_W-1];
        mag = neg ? (10'h200 - {1'b0, req}) : {1'b0, req};
        if (mag > 10'(lrs_pkg::MAX_STEP_REQUEST))
            mag = 10'(lrs_pkg::MAX_STEP_REQUEST);
        // Equal spans count as mostly vertical
        vert = (x_span <= y_span);
        major_d = vert ? y_span : x_span;
        minor_d = vert ? x_span : y_span;
        major_n = 0;
        minor_n = 0;
        for (int i = 0; i < int'(mag); i++)
        begin
            err_acc = err_acc + {1'b0, minor_d};
            if (err_acc >= {1'b0, major_d})
            begin
                minor_n++;
                err_acc = err_acc - {1'b0, major_d};
            end
            major_n++;
            if (steps_taken != {lrs_pkg::TOTAL_W{1'b1}})
                steps_taken = steps_taken + 1'b1;
        end
        ox = vert ? minor_n : major_n;
        oy = vert ? major_n : minor_n;
        if (lrs_pkg::QUAD_NEG_X[quad_sel])
            ox = -ox;
        if (lrs_pkg::QUAD_NEG_Y[quad_sel])
            oy = -oy;
        if (neg)
        begin
            ox = -ox;
            oy = -oy;
        end
        r.off_x = ox[lrs_pkg::CNT_W-1:0];
        r.off_y = oy[lrs_pkg::CNT_W-1:0];
        r.end_flag = ray_endless || ((32'(steps_taken) + 1) >= 32'(major_d));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_span = lrs_pkg::DELTA_X_RESET;
            y_span = lrs_pkg::DELTA_Y_RESET;
            quad_sel = lrs_pkg::QUADRANT_RESET;
            ray_endless = lrs_pkg::ENDLESS_RESET;
            err_acc = '0;
            steps_taken = '0;
            expected_offsets.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // Retire the result before taking a new request in the same cycle
            if (out_valid && out_ready)
            begin
                if (expected_offsets.size() == 0)
                begin
                    $error("unexpected result: offset_x %0d offset_y %0d at_end %0d",
                           offset_x, offset_y, at_end);
                    fail_count++;
                end
                else
                begin
                    want = expected_offsets.pop_front();
                    if (offset_x !== want.off_x)
                    begin
                        $error("offset_x mismatch: expected %0d, actual %0d",
                               $signed(want.off_x), offset_x);
                        fail_count++;
                    end
                    if (offset_y !== want.off_y)
                    begin
                        $error("offset_y mismatch: expected %0d, actual %0d",
                               $signed(want.off_y), offset_y);
                        fail_count++;
                    end
                    if (at_end !== want.end_flag)
                    begin
                        $error("at_end mismatch: expected %0d, actual %0d",
                               want.end_flag, at_end);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    lrs_pkg::REG_DELTA_X:  x_span = cfg_data;
                    lrs_pkg::REG_DELTA_Y:  y_span = cfg_data;
                    lrs_pkg::REG_QUADRANT: quad_sel = cfg_data[1:0];
                    lrs_pkg::REG_ENDLESS:  ray_endless = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_offsets.push_back(advance_ray(step_count));
            pending = expected_offsets.size();
        end
    end

endmodule

### sim/tb_top.sv
// Stimulus and verdict for the line ray stepper, with the offset checker beside it.
module tb_top;

    localparam int HOLD_CYCLES = 300;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [lrs_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [lrs_pkg::DELTA_W-1:0]      cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic signed [lrs_pkg::REQ_W-1:0] step_count = '0;
    logic                             out_ready = 1'b0;
    wire                              in_ready;
    wire                              out_valid;
    wire signed [lrs_pkg::CNT_W-1:0]  offset_x;
    wire signed [lrs_pkg::CNT_W-1:0]  offset_y;
    wire                              at_end;
    int                               fail_count;
    int                               pending;

    // Stimulus controls: calm stops idling on both sides, hold_seq asks for long receiver hold-offs
    logic                             calm = 1'b0;
    int                               hold_seq = 0;

    line_ray_stepper_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .step_count (step_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .offset_x   (offset_x),
        .offset_y   (offset_y),
        .at_end     (at_end)
    );

    ray_offset_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .step_count (step_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .offset_x   (offset_x),
        .offset_y   (offset_y),
        .at_end     (at_end),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random stalls, with a hold-off counted here on request
    initial
    begin
        int holds_served;
        int hold_left;
        holds_served = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != holds_served)
            begin
                holds_served = holds_served + 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 24);
        end
    end

    task automatic send_request(logic signed [lrs_pkg::REQ_W-1:0] steps);
        if (!calm)
        begin
            while ($urandom_range(99) < 24)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        step_count <= steps;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every result has come back
    task automatic settle;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_ray_config(logic [lrs_pkg::DELTA_W-1:0] dx,
                                    logic [lrs_pkg::DELTA_W-1:0] dy,
                                    logic [1:0] quad, logic endl);
        cfg_we <= 1'b1;
        cfg_index <= lrs_pkg::REG_DELTA_X;
        cfg_data <= dx;
        @(posedge clk);
        cfg_index <= lrs_pkg::REG_DELTA_Y;
        cfg_data <= dy;
        @(posedge clk);
        cfg_index <= lrs_pkg::REG_QUADRANT;
        cfg_data <= {8'b0, quad};
        @(posedge clk);
        cfg_index <= lrs_pkg::REG_ENDLESS;
        cfg_data <= {9'b0, endl};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [lrs_pkg::DELTA_W-1:0] pick_span();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return '0;
        else if (roll < 20)
            return '1;
        return lrs_pkg::DELTA_W'($urandom_range(1023));
    endfunction

    function automatic logic signed [lrs_pkg::REQ_W-1:0] pick_steps(bit long_rays);
        int roll;
        roll = $urandom_range(99);
        if (long_rays && roll < 90)
            return $urandom_range(1) ? 9'h0FF : 9'h101;
        else if (roll < 80)
            return lrs_pkg::REQ_W'($urandom_range(16)) - 9'd8;
        else if (roll < 95)
            return lrs_pkg::REQ_W'($urandom_range(80)) - 9'd40;
        return lrs_pkg::REQ_W'($urandom_range(511));
    endfunction

    initial
    begin
        int count;
        int wait_left;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default configuration: endless ray along x
        send_request(9'sd0);
        send_request(9'sd1);
        send_request(-9'sd1);
        settle();
        // Shallow ray, far from its end
        write_ray_config(10'd1023, 10'd1, 2'd3, 1'b0);
        send_request(9'sd2);
        send_request(9'sd0);
        send_request(-9'sd3);
        send_request(9'sd5);
        settle();
        // Both spans zero: every step diagonal, always at the end
        write_ray_config(10'd0, 10'd0, 2'd1, 1'b0);
        send_request(9'sd3);
        send_request(-9'sd3);
        settle();
        // Equal spans
        write_ray_config(10'd7, 10'd7, 2'd2, 1'b1);
        send_request(9'sd4);
        send_request(-9'sd2);
        settle();
        // Field extremes, clamp of the most negative request
        write_ray_config(10'd3, 10'd1000, 2'd0, 1'b0);
        send_request(9'sd255);
        send_request(9'h100);
        send_request(9'sd170);
        send_request(-9'sd171);
        send_request(-9'sd255);

        for (int p = 0; p < 11; p++)
        begin
            settle();
            case (p)
                0: write_ray_config(10'd1023, 10'd0, 2'd0, 1'b0);
                1: write_ray_config(10'd0, 10'd1023, 2'd1, 1'b1);
                2: write_ray_config(10'd1023, 10'd1023, 2'd2, 1'b0);
                default: write_ray_config(pick_span(), pick_span(),
                                          2'($urandom_range(3)), 1'($urandom_range(1)));
            endcase
            if (p == 3)
                calm <= 1'b1;
            // Stall results for a while so the block fills and blocks requests
            if (p == 5)
                hold_seq <= hold_seq + 1;
            // Long rays drive the step total into saturation
            count = (p == 7) ? 300 : 73;
            repeat (count)
                send_request(pick_steps(p == 7));
            settle();
            calm <= 1'b0;
        end

        in_valid <= 1'b0;
        wait_left = 5000;
        while (pending != 0 && wait_left > 0)
        begin
            @(negedge clk);
            wait_left = wait_left - 1;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### line_ray_stepper_unit.f
sv/lrs_pkg.sv
sv/lrs_step_core.sv
sv/line_ray_stepper_unit.sv
sim/ray_offset_checker.sv
sim/tb_top.sv
